[hdl/ddma_pkg.sv]
`timescale 1ns / 1ps

package ddma_pkg;

    localparam int DEF_CHANNELS        = 16;
    localparam int DEF_REQ_MAP_ENTRIES = 40;
    localparam int DEF_MAX_CHAIN       = 4096;

    localparam logic [1:0] CMD_REG_RD   = 2'd0;
    localparam logic [1:0] CMD_REG_WR   = 2'd1;
    localparam logic [1:0] CMD_BUS_RESP = 2'd2;
    localparam logic [1:0] CMD_BUS_ACK  = 2'd3;

    localparam logic [11:0] DINT_OFF  = 12'h0F0;
    localparam logic [11:0] RMAP_BASE = 12'h100;
    localparam logic [11:0] CREG_BASE = 12'h200;

    localparam logic [31:0] ST_RUN     = 32'h8000_0000;
    localparam logic [31:0] ST_NODESC  = 32'h4000_0000;
    localparam logic [31:0] ST_STOPIE  = 32'h2000_0000;
    localparam logic [31:0] ST_STOPPED = 32'h0000_0008;
    localparam logic [31:0] ST_FLAGS   = 32'h0000_0007;
    localparam logic [31:0] ST_ENDI    = 32'h0000_0004;
    localparam logic [31:0] ST_STARTI  = 32'h0000_0002;
    localparam logic [31:0] ST_BUSERR  = 32'h0000_0001;
    localparam logic [31:0] ST_RW_MASK = ST_RUN | ST_NODESC | ST_STOPIE;

    localparam int CM_INCS_BIT    = 31;
    localparam int CM_INCT_BIT    = 30;
    localparam int CM_STARTIE_BIT = 22;
    localparam int CM_ENDIE_BIT   = 21;
    localparam int CM_WIDTH_LSB   = 14;
    localparam logic [31:0] CM_LEN = 32'h0000_1FFF;

    localparam logic [1:0] REG_NEXT = 2'd0;
    localparam logic [1:0] REG_SRC  = 2'd1;
    localparam logic [1:0] REG_TGT  = 2'd2;
    localparam logic [1:0] REG_CMD  = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic accept;
        logic reg_access;
        logic buserr;
        logic stop;
        logic desc_issue;
        logic desc_store;
        logic xfer_start;
        logic unit_write;
        logic unit_next;
        logic done;
        logic chain_inc;
        logic kick;
        logic load_out;
    } ddma_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ok;
        logic       run;
        logic       nodesc;
        logic       next_end;
        logic       len_zero;
        logic       more;
        logic       limit;
        logic       pend_any;
        logic       idx_last;
        logic       out_free;
    } ddma_stat_t;

    function automatic logic [1:0] unit_code(input logic [1:0] wfield);
        logic [1:0] code;
        case (wfield)
            2'd1:    code = SIZE_BYTE;
            2'd2:    code = SIZE_HALF;
            default: code = SIZE_WORD;
        endcase
        return code;
    endfunction

endpackage

[hdl/ddma_ctrl.sv]
`timescale 1ns / 1ps

module ddma_ctrl
    import ddma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ddma_stat_t stat,
    output ddma_op_t   op
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DESC = 3'd2;
    localparam logic [2:0] S_XFER = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_KICK = 3'd5;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DESC  = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;
    localparam logic [1:0] PH_WRITE = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        op         = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op.accept  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_KICK;
                if (stat.cmd == CMD_REG_RD || stat.cmd == CMD_REG_WR)
                begin
                    op.reg_access = 1'b1;
                end
                else if (stat.cmd == CMD_BUS_RESP && phase_reg == PH_DESC)
                begin
                    if (!stat.ok)
                    begin
                        op.buserr  = 1'b1;
                        op.stop    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        op.desc_store = 1'b1;
                        if (stat.idx_last)
                            state_next = S_XFER;
                    end
                end
                else if (stat.cmd == CMD_BUS_RESP && phase_reg == PH_READ)
                begin
                    if (!stat.ok)
                    begin
                        op.buserr  = 1'b1;
                        op.stop    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        op.unit_write = 1'b1;
                        phase_next    = PH_WRITE;
                    end
                end
                else if (stat.cmd == CMD_BUS_ACK && phase_reg == PH_WRITE)
                begin
                    if (!stat.ok)
                    begin
                        op.buserr  = 1'b1;
                        op.stop    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (stat.more)
                    begin
                        op.unit_next = 1'b1;
                        phase_next   = PH_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DESC:
            begin
                state_next = S_KICK;
                if (!stat.run || (!stat.nodesc && stat.next_end))
                begin
                    op.stop    = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (stat.nodesc)
                begin
                    state_next = S_XFER;
                end
                else
                begin
                    op.desc_issue = 1'b1;
                    phase_next    = PH_DESC;
                end
            end
            S_XFER:
            begin
                if (stat.len_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op.xfer_start = 1'b1;
                    phase_next    = PH_READ;
                    state_next    = S_KICK;
                end
            end
            S_DONE:
            begin
                op.done = 1'b1;
                if (stat.nodesc || stat.limit)
                begin
                    op.stop    = 1'b1;
                    phase_next = PH_IDLE;
                    state_next = S_KICK;
                end
                else
                begin
                    op.chain_inc = 1'b1;
                    state_next   = S_DESC;
                end
            end
            S_KICK:
            begin
                if (phase_reg == PH_IDLE && stat.pend_any)
                begin
                    op.kick    = 1'b1;
                    state_next = S_DESC;
                end
                else if (stat.out_free)
                begin
                    op.load_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/ddma_dpath.sv]
`timescale 1ns / 1ps

module ddma_dpath
    import ddma_pkg::*;
#(
    parameter int CHANNELS        = DEF_CHANNELS,
    parameter int REQ_MAP_ENTRIES = DEF_REQ_MAP_ENTRIES,
    parameter int MAX_CHAIN       = DEF_MAX_CHAIN
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ddma_op_t     op,
    output ddma_stat_t   stat,
    input  logic [1:0]   in_tuser,
    input  logic [79:0]  in_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW = (REQ_MAP_ENTRIES > 1) ? $clog2(REQ_MAP_ENTRIES) : 1;
    localparam int KW = $clog2(MAX_CHAIN + 1);
    localparam logic [11:0] ST_END = 12'(4 * CHANNELS);
    localparam logic [11:0] CR_END = 12'(512 + 16 * CHANNELS);

    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic        bytew_reg;
    logic [31:0] wdata_reg;
    logic        ok_reg;
    logic [31:0] rdata_reg;

    logic [31:0] status_reg [CHANNELS];
    logic [31:0] next_reg   [CHANNELS];
    logic [31:0] src_reg    [CHANNELS];
    logic [31:0] tgt_reg    [CHANNELS];
    logic [31:0] cmdw_reg   [CHANNELS];

    logic [31:0] rmap_mem [REQ_MAP_ENTRIES];
    logic [REQ_MAP_ENTRIES-1:0] rmap_valid_reg;
    logic [31:0] rmap_q_reg;
    logic        rmap_qv_reg;

    logic [CW-1:0]       active_reg;
    logic [1:0]          idx_reg;
    logic [31:0]         fetched_reg;
    logic [12:0]         off_reg;
    logic [KW-1:0]       chain_reg;
    logic [CHANNELS-1:0] pend_reg;

    logic        q_valid_reg, q_write_reg;
    logic [31:0] q_addr_reg, q_data_reg;
    logic [1:0]  q_size_reg;
    logic [31:0] res_rd_reg;
    logic        res_fault_reg;

    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    logic [11:0] eff_in, eff;
    logic [5:0]  rm_in6, rm6;
    logic [RW-1:0] rm_rd_idx, rm_wr_idx;
    logic        is_st, is_dint, is_rm, is_cr, hit;
    logic [CW-1:0] sel_raw, sel;
    logic [31:0] st_v, nd_v, src_v, tgt_v, cm_v, rv;
    logic [CHANNELS-1:0] irq_vec;
    logic [4:0]  sh;
    logic [31:0] lane, keep, wv, rd_val, st_wr;
    logic        do_wr;
    logic        rise;
    logic [2:0]  ubytes;
    logic [13:0] off_nxt;
    logic        more;
    logic [KW:0] chain_p1;
    logic [31:0] desc_base;
    logic [12:0] uoff;
    logic [31:0] rd_addr, wr_addr, wmask;
    logic [CW-1:0] kick_ch;
    logic [31:0] st_eng;
    logic        st_we;
    logic [1:0]  nidx;

    assign eff_in = in_tdata[12] ? {in_tdata[11:2], 2'b00} : in_tdata[11:0];
    assign rm_in6 = eff_in[7:2];
    assign rm_rd_idx = ({1'b0, rm_in6} < 7'(REQ_MAP_ENTRIES)) ? rm_in6[RW-1:0] : '0;

    assign eff   = bytew_reg ? {addr_reg[11:2], 2'b00} : addr_reg;
    assign rm6   = eff[7:2];
    assign rm_wr_idx = rm6[RW-1:0];
    assign is_st   = (eff < ST_END);
    assign is_dint = (eff == DINT_OFF);
    assign is_rm   = (eff >= RMAP_BASE) && (eff < CREG_BASE) &&
                     ({1'b0, rm6} < 7'(REQ_MAP_ENTRIES));
    assign is_cr   = (eff >= CREG_BASE) && (eff < CR_END) && (eff[1:0] == 2'b00);
    assign hit     = is_st || is_dint || is_rm || is_cr;

    always_comb
    begin
        if (op.reg_access)
            sel_raw = is_st ? eff[CW+1:2] : eff[CW+3:4];
        else
            sel_raw = active_reg;
        sel = ({1'b0, sel_raw} < (CW+1)'(CHANNELS)) ? sel_raw : '0;
    end

    assign st_v  = status_reg[sel];
    assign nd_v  = next_reg[sel];
    assign src_v = src_reg[sel];
    assign tgt_v = tgt_reg[sel];
    assign cm_v  = cmdw_reg[sel];

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            irq_vec[i] = (|status_reg[i][2:0]) || (status_reg[i][3] && status_reg[i][29]);
    end

    always_comb
    begin
        if (is_st)
            rv = st_v;
        else if (is_dint)
            rv = 32'(irq_vec);
        else if (is_rm)
            rv = rmap_qv_reg ? rmap_q_reg : 32'd0;
        else
        begin
            case (eff[3:2])
                REG_NEXT: rv = nd_v;
                REG_SRC:  rv = src_v;
                REG_TGT:  rv = tgt_v;
                REG_CMD:  rv = cm_v;
                default:  rv = cm_v;
            endcase
        end
    end

    assign sh     = {addr_reg[1:0], 3'b000};
    assign lane   = 32'h0000_00FF << sh;
    assign keep   = rv & ~lane & (is_st ? ~ST_FLAGS : 32'hFFFF_FFFF);
    assign wv     = bytew_reg ? (keep | ({24'd0, wdata_reg[7:0]} << sh)) : wdata_reg;
    assign rd_val = bytew_reg ? ((rv >> sh) & 32'h0000_00FF) : rv;
    assign do_wr  = op.reg_access && (cmd_reg == CMD_REG_WR) && hit;

    always_comb
    begin
        st_wr = st_v & ~(wv & ST_FLAGS);
        st_wr = (st_wr & ~ST_RW_MASK) | (wv & ST_RW_MASK);
        rise  = !st_v[31] && st_wr[31];
        if (rise)
            st_wr = st_wr & ~ST_STOPPED;
    end

    always_comb
    begin
        case (cm_v[CM_WIDTH_LSB +: 2])
            2'd1:    ubytes = 3'd1;
            2'd2:    ubytes = 3'd2;
            default: ubytes = 3'd4;
        endcase
    end

    assign off_nxt   = {1'b0, off_reg} + 14'(ubytes);
    assign more      = off_nxt < {1'b0, cm_v[12:0]};
    assign chain_p1  = {1'b0, chain_reg} + (KW+1)'(1);
    assign desc_base = nd_v & ~32'hF;
    assign uoff      = op.unit_next ? off_nxt[12:0] : 13'd0;
    assign rd_addr   = cm_v[CM_INCS_BIT] ? src_v + 32'(uoff) : src_v;
    assign wr_addr   = cm_v[CM_INCT_BIT] ? tgt_v + 32'(off_reg) : tgt_v;
    assign nidx      = idx_reg + 2'd1;

    always_comb
    begin
        case (cm_v[CM_WIDTH_LSB +: 2])
            2'd1:    wmask = 32'h0000_00FF;
            2'd2:    wmask = 32'h0000_FFFF;
            default: wmask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb
    begin
        kick_ch = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
            if (pend_reg[i])
                kick_ch = CW'(i);
    end

    always_comb
    begin
        st_eng = st_v;
        if (op.buserr)
            st_eng = st_eng | ST_BUSERR;
        if (op.desc_store && idx_reg == 2'd3 && rdata_reg[CM_STARTIE_BIT])
            st_eng = st_eng | ST_STARTI;
        if (op.done && cm_v[CM_ENDIE_BIT])
            st_eng = st_eng | ST_ENDI;
        if (op.stop)
            st_eng = (st_eng & ~ST_RUN) | ST_STOPPED;
    end

    assign st_we = op.buserr || op.desc_store || op.done || op.stop;

    always_ff @(posedge clk)
    begin
        if (do_wr && is_rm)
            rmap_mem[rm_wr_idx] <= wv;
        if (op.accept)
            rmap_q_reg <= rmap_mem[rm_rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (op.accept)
        begin
            cmd_reg   <= in_tuser;
            addr_reg  <= in_tdata[11:0];
            bytew_reg <= in_tdata[12];
            wdata_reg <= in_tdata[44:13];
            ok_reg    <= in_tdata[45];
            rdata_reg <= in_tdata[77:46];
        end
        if (op.load_out)
            m_tdata_reg <= {2'b00, q_data_reg, q_size_reg, q_addr_reg, q_write_reg,
                            q_valid_reg, |irq_vec, res_fault_reg, res_rd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                status_reg[i] <= '0;
                next_reg[i]   <= '0;
                src_reg[i]    <= '0;
                tgt_reg[i]    <= '0;
                cmdw_reg[i]   <= '0;
            end
            rmap_valid_reg <= '0;
            rmap_qv_reg    <= 1'b0;
            active_reg     <= '0;
            idx_reg        <= '0;
            fetched_reg    <= '0;
            off_reg        <= '0;
            chain_reg      <= '0;
            pend_reg       <= '0;
            q_valid_reg    <= 1'b0;
            q_write_reg    <= 1'b0;
            q_addr_reg     <= '0;
            q_size_reg     <= '0;
            q_data_reg     <= '0;
            res_rd_reg     <= '0;
            res_fault_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (op.accept)
            begin
                rmap_qv_reg   <= rmap_valid_reg[rm_rd_idx];
                q_valid_reg   <= 1'b0;
                q_write_reg   <= 1'b0;
                q_addr_reg    <= '0;
                q_size_reg    <= '0;
                q_data_reg    <= '0;
                res_rd_reg    <= '0;
                res_fault_reg <= 1'b0;
            end

            if (op.reg_access)
            begin
                res_fault_reg <= !hit;
                if (cmd_reg == CMD_REG_RD && hit)
                    res_rd_reg <= rd_val;
            end

            if (do_wr && is_rm)
                rmap_valid_reg[rm_wr_idx] <= 1'b1;

            if (do_wr && is_st)
            begin
                status_reg[sel] <= st_wr;
                if (rise)
                    pend_reg[sel] <= 1'b1;
            end
            else if (st_we)
            begin
                status_reg[sel] <= st_eng;
            end

            if (do_wr && is_cr)
            begin
                case (eff[3:2])
                    REG_NEXT: next_reg[sel] <= wv;
                    REG_SRC:  src_reg[sel]  <= wv;
                    REG_TGT:  tgt_reg[sel]  <= wv;
                    REG_CMD:  cmdw_reg[sel] <= wv;
                    default:  cmdw_reg[sel] <= wv;
                endcase
            end

            if (op.desc_store)
            begin
                case (idx_reg)
                    REG_NEXT: fetched_reg  <= rdata_reg;
                    REG_SRC:  src_reg[sel] <= rdata_reg;
                    REG_TGT:  tgt_reg[sel] <= rdata_reg;
                    REG_CMD:
                    begin
                        cmdw_reg[sel] <= rdata_reg;
                        next_reg[sel] <= fetched_reg;
                    end
                    default:  fetched_reg <= rdata_reg;
                endcase
                if (idx_reg != 2'd3)
                begin
                    idx_reg     <= nidx;
                    q_valid_reg <= 1'b1;
                    q_write_reg <= 1'b0;
                    q_addr_reg  <= desc_base + 32'({nidx, 2'b00});
                    q_size_reg  <= SIZE_WORD;
                    q_data_reg  <= '0;
                end
            end

            if (op.desc_issue)
            begin
                idx_reg     <= '0;
                q_valid_reg <= 1'b1;
                q_write_reg <= 1'b0;
                q_addr_reg  <= desc_base;
                q_size_reg  <= SIZE_WORD;
                q_data_reg  <= '0;
            end

            if (op.xfer_start || op.unit_next)
            begin
                off_reg     <= uoff;
                q_valid_reg <= 1'b1;
                q_write_reg <= 1'b0;
                q_addr_reg  <= rd_addr;
                q_size_reg  <= unit_code(cm_v[CM_WIDTH_LSB +: 2]);
                q_data_reg  <= '0;
            end

            if (op.unit_write)
            begin
                q_valid_reg <= 1'b1;
                q_write_reg <= 1'b1;
                q_addr_reg  <= wr_addr;
                q_size_reg  <= unit_code(cm_v[CM_WIDTH_LSB +: 2]);
                q_data_reg  <= rdata_reg & wmask;
            end

            if (op.done)
                cmdw_reg[sel] <= cm_v & ~CM_LEN;

            if (op.chain_inc)
                chain_reg <= chain_p1[KW-1:0];

            if (op.kick)
            begin
                pend_reg[kick_ch] <= 1'b0;
                active_reg        <= kick_ch;
                chain_reg         <= '0;
            end

            if (op.load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.cmd      = cmd_reg;
    assign stat.ok       = ok_reg;
    assign stat.run      = st_v[31];
    assign stat.nodesc   = st_v[30];
    assign stat.next_end = nd_v[0];
    assign stat.len_zero = (cm_v[12:0] == 13'd0);
    assign stat.more     = more;
    assign stat.limit    = (chain_p1 >= (KW+1)'(MAX_CHAIN));
    assign stat.pend_any = |pend_reg;
    assign stat.idx_last = (idx_reg == 2'd3);
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

[hdl/descriptor_dma_controller.sv]
`timescale 1ns / 1ps

// Descriptor DMA controller, one bus event per input item.
// s_* channel: s_tuser carries the command (register read, register write,
// bus read response, bus write acknowledge); s_tdata the register offset,
// access size, write data, bus status and bus read data.
// m_* channel: one result item per input item with the register read data,
// the fault flag, the interrupt level and at most one new bus request.
// A channel start adds engine steps to the same item (descriptor check,
// transfer start, descriptor completion) before its result is loaded.
// The control sequencer handles one item at a time and walks engine steps
// one per cycle, holding in its last step while the output register is full.
// The result sits in an output register, so a stalled receiver only
// delays the next item once that register is still full at its end.
// Reset clears all channel registers, the request map valid bits and the engine.
module descriptor_dma_controller
    import ddma_pkg::*;
#(
    parameter int CHANNELS        = DEF_CHANNELS,
    parameter int REQ_MAP_ENTRIES = DEF_REQ_MAP_ENTRIES,
    parameter int MAX_CHAIN       = DEF_MAX_CHAIN
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [79:0]  s_tdata,   // reg_addr, byte_access, write_data, bus_ok, bus_read_data
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // read_data, access_fault, irq, req_valid, req_write,
                                    // req_addr, req_size, req_write_data
);

    ddma_op_t   op;
    ddma_stat_t stat;

    ddma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    ddma_dpath #(
        .CHANNELS        (CHANNELS),
        .REQ_MAP_ENTRIES (REQ_MAP_ENTRIES),
        .MAX_CHAIN       (MAX_CHAIN)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .stat     (stat),
        .in_tuser (s_tuser),
        .in_tdata (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/ddma_checker.sv]
`timescale 1ns / 1ps

module ddma_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous one in work");

    a_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[69:68] != 2'd3)
        else $error("illegal request size");

    a_no_req_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[34] |-> !m_tdata[35] && m_tdata[101:36] == '0)
        else $error("request fields set without request");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("faulting access returned data");

endmodule

bind descriptor_dma_controller ddma_checker u_ddma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
